// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked only while out of reset.
`define PND_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pnd assertion failed");
// Checked at every edge, reset included.
`define PND_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pnd assertion failed");
`endif

// File: hw/rtl/pnd_pkg.sv
// Constants, types and table functions for the 2D gradient noise pipeline.
// Depends on nothing.
`default_nettype none
package pnd_pkg;

    localparam int COORD_FRAC_BITS    = 16;
    localparam int ANGLE_TABLE_BITS   = 10;
    localparam int GRADIENT_FRAC_BITS = 15;

    localparam int F  = COORD_FRAC_BITS;
    localparam int A  = ANGLE_TABLE_BITS;
    localparam int G  = GRADIENT_FRAC_BITS;
    localparam int GW = G + 2;                 // signed gradient component
    localparam int QN = 2 ** (A - 2);          // entries per quadrant
    localparam int DOT_W = 19;                 // signed Q16 corner value

    localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C = 32'd2048419325;
    localparam logic [63:0] PI_Q61     = 64'h6487ED5110B4611A;

    // quadrant codes of a gradient index
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic signed [GW-1:0] c;
        logic signed [GW-1:0] s;
    } grad_t;

    function automatic logic [31:0] rotl16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // Q30 to QG, round half away from zero
    function automatic logic signed [GW-1:0] to_grad(input longint v);
        longint unsigned mag;
        longint unsigned m;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        m = (mag + (64'd1 << (29 - G))) >> (30 - G);
        return (v < 0) ? -GW'(m) : GW'(m);
    endfunction

    // cos and sin of the first-quadrant angle r, Taylor series in Q30
    function automatic grad_t quarter_of(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint s;
        longint c;
        grad_t g;
        x  = (64'(r) * (PI_Q61 >> A) + (64'd1 << 29)) >> 30;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        s  = longint'(ts);
        c  = longint'(tc);
        ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
        s = s - longint'(ts);         c = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
        s = s + longint'(ts);         c = c + longint'(tc);
        ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
        s = s - longint'(ts);         c = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
        s = s + longint'(ts);         c = c + longint'(tc);
        ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
        s = s - longint'(ts);         c = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
        s = s + longint'(ts);         c = c + longint'(tc);
        ts = ((ts * x2) >> 30) / 210; tc = ((tc * x2) >> 30) / 182;
        s = s - longint'(ts);         c = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 272; tc = ((tc * x2) >> 30) / 240;
        s = s + longint'(ts);         c = c + longint'(tc);
        ts = ((ts * x2) >> 30) / 342; tc = ((tc * x2) >> 30) / 306;
        s = s - longint'(ts);         c = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 420; tc = ((tc * x2) >> 30) / 380;
        s = s + longint'(ts);         c = c + longint'(tc);
        ts = ((ts * x2) >> 30) / 506; tc = ((tc * x2) >> 30) / 462;
        s = s - longint'(ts);         c = c - longint'(tc);
        ts = ((ts * x2) >> 30) / 600; tc = ((tc * x2) >> 30) / 552;
        s = s + longint'(ts);         c = c + longint'(tc);
        g.c = to_grad(c);
        g.s = to_grad(s);
        return g;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/perlin_noise_2d_top.sv
// 2D gradient noise top level: cell split, dot products, blends, output.
// Depends on pnd_pkg, pnd_hash, pnd_grad_lut, pnd_fade.
//
// Usage:
//   Input channel in_valid/in_ready carries one point per beat: x_coord and
//   y_coord, signed Q16.16. Output channel out_valid/out_ready carries one
//   noise_value per beat, unsigned Q0.16, in input order.
//   Throughput: one point per cycle while the output side is not stalled.
//   The pipeline is twelve register stages, each with its own valid bit;
//   the deepest logic per stage is one 32x32 hash multiply.
//   A stage loads whenever it is empty or the stage after it moves on, so
//   bubbles are squeezed out and a point is still taken while a finished
//   result waits at the output register.
//   When the receiver holds out_ready low the output beat holds steady and
//   stalls ripple back; in_ready drops only once every stage is full.
//   Reset (rst_n low, asynchronous) empties all stages; payload registers
//   are not cleared.
//   Stage map: 1 cell split, 2-4 hash and weight, 5 gradient table,
//   6-7 dot products, 8-9 x blend, 10-11 y blend, 12 output mapping.
`default_nettype none
module perlin_noise_2d_top
    import pnd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] x_coord,
    input  wire logic signed [31:0] y_coord,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             noise_value
);

    localparam int NSTG = 12;
    localparam int PW   = F + 1 + GW;        // one dot product term
    localparam int SH   = F + G - 16;        // dot back to Q16
    localparam int LW   = DOT_W + F + 3;     // lerp product
    localparam int OW   = DOT_W + 2;

    // ---------------- stage control ----------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    // ---------------- stage 1: cell and fraction ----------------
    logic [31:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic [F-1:0] fx_reg [5];
    logic [F-1:0] fy_reg [5];
    logic [31:0]  x0_next, y0_next;

    assign x0_next = 32'(x_coord >>> F);
    assign y0_next = 32'(y_coord >>> F);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg    <= x0_next;
            x1_reg    <= x0_next + 32'd1;
            y0_reg    <= y0_next;
            y1_reg    <= y0_next + 32'd1;
            fx_reg[0] <= x_coord[F-1:0];
            fy_reg[0] <= y_coord[F-1:0];
        end
    end

    // fractions ride along until the dot stage
    always_ff @(posedge clk)
    begin
        for (int k = 1; k < 5; k++)
        begin
            if (en[k])
            begin
                fx_reg[k] <= fx_reg[k-1];
                fy_reg[k] <= fy_reg[k-1];
            end
        end
    end

    // ---------------- stages 2-4: hash and weights ----------------
    logic [A-1:0] idx [4];
    logic [F:0]   sx4, sy4;

    pnd_hash u_hash (
        .clk (clk),
        .en  (en[3:1]),
        .x0  (x0_reg),
        .x1  (x1_reg),
        .y0  (y0_reg),
        .y1  (y1_reg),
        .idx (idx)
    );

    pnd_fade u_fade_x (
        .clk (clk),
        .en  (en[3:1]),
        .f   (fx_reg[0]),
        .s   (sx4)
    );

    pnd_fade u_fade_y (
        .clk (clk),
        .en  (en[3:1]),
        .f   (fy_reg[0]),
        .s   (sy4)
    );

    // weights carried: sx to stage 7, sy to stage 9
    logic [F:0] sx_reg [3];
    logic [F:0] sy_reg [5];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sx_reg[0] <= sx4;
            sy_reg[0] <= sy4;
        end
        for (int k = 1; k < 3; k++)
        begin
            if (en[k+4])
            begin
                sx_reg[k] <= sx_reg[k-1];
            end
        end
        for (int k = 1; k < 5; k++)
        begin
            if (en[k+4])
            begin
                sy_reg[k] <= sy_reg[k-1];
            end
        end
    end

    // ---------------- stage 5: gradients ----------------
    logic signed [GW-1:0] gx [4];
    logic signed [GW-1:0] gy [4];

    pnd_grad_lut u_lut (
        .clk (clk),
        .en  (en[4]),
        .idx (idx),
        .gx  (gx),
        .gy  (gy)
    );

    // ---------------- stage 6: offset times gradient ----------------
    // far offset f-2^F is {1,f} as an F+1 bit signed word
    logic signed [F:0]    dx [4];
    logic signed [F:0]    dy [4];
    logic signed [PW-1:0] px_reg [4];
    logic signed [PW-1:0] py_reg [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            dx[c] = $signed({(c % 2) == 1, fx_reg[4]});
            dy[c] = $signed({c >= 2, fy_reg[4]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int c = 0; c < 4; c++)
            begin
                px_reg[c] <= PW'(dx[c] * gx[c]);
                py_reg[c] <= PW'(dy[c] * gy[c]);
            end
        end
    end

    // ---------------- stage 7: dot sums in Q16 ----------------
    logic signed [DOT_W-1:0] n_reg [4];
    logic signed [PW:0]      dsum [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            dsum[c] = (PW + 1)'(px_reg[c]) + (PW + 1)'(py_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int c = 0; c < 4; c++)
            begin
                n_reg[c] <= DOT_W'(dsum[c] >>> SH);
            end
        end
    end

    // ---------------- stages 8-9: blend along x ----------------
    logic signed [LW-1:0]    lxp_reg [2];
    logic signed [DOT_W-1:0] lxb_reg [2];
    logic signed [DOT_W-1:0] lx_reg [2];
    logic signed [F+1:0]     sx_s;

    assign sx_s = $signed({1'b0, sx_reg[2]});

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            lxp_reg[0] <= LW'((DOT_W + 1)'(n_reg[1]) - (DOT_W + 1)'(n_reg[0])) * sx_s;
            lxp_reg[1] <= LW'((DOT_W + 1)'(n_reg[3]) - (DOT_W + 1)'(n_reg[2])) * sx_s;
            lxb_reg[0] <= n_reg[0];
            lxb_reg[1] <= n_reg[2];
        end
        if (en[8])
        begin
            lx_reg[0] <= lxb_reg[0] + DOT_W'(lxp_reg[0] >>> F);
            lx_reg[1] <= lxb_reg[1] + DOT_W'(lxp_reg[1] >>> F);
        end
    end

    // ---------------- stages 10-11: blend along y ----------------
    logic signed [LW-1:0]    lyp_reg;
    logic signed [DOT_W-1:0] lyb_reg;
    logic signed [DOT_W-1:0] v_val_reg;
    logic signed [F+1:0]     sy_s;

    assign sy_s = $signed({1'b0, sy_reg[4]});

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            lyp_reg <= LW'((DOT_W + 1)'(lx_reg[1]) - (DOT_W + 1)'(lx_reg[0])) * sy_s;
            lyb_reg <= lx_reg[0];
        end
        if (en[10])
        begin
            v_val_reg <= lyb_reg + DOT_W'(lyp_reg >>> F);
        end
    end

    // ---------------- stage 12: map to [0,1) and saturate ----------------
    logic signed [OW-1:0] mapped;
    logic [15:0]          noise_reg;
    logic [15:0]          noise_next;

    assign mapped = (OW'(v_val_reg) + OW'(65536)) >>> 1;

    always_comb
    begin
        if (mapped < 0)
        begin
            noise_next = 16'd0;
        end
        else if (mapped > OW'(65535))
        begin
            noise_next = 16'hFFFF;
        end
        else
        begin
            noise_next = mapped[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            noise_reg <= noise_next;
        end
    end

    assign noise_value = noise_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pnd_hash.sv
// Corner hash: three wrapping 32-bit multiplies over three stages.
// Depends on pnd_pkg.
`default_nettype none
module pnd_hash
    import pnd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic [2:0]    en,      // load enables, stages 2..4
    input  wire logic [31:0]   x0,
    input  wire logic [31:0]   x1,
    input  wire logic [31:0]   y0,
    input  wire logic [31:0]   y1,
    output logic      [A-1:0]  idx [4]  // corners 00, 10, 01, 11
);

    logic [31:0] ha_reg [2];
    logic [31:0] y0_reg;
    logic [31:0] y1_reg;
    logic [31:0] hb_ha_reg [2];
    logic [31:0] b_reg [4];
    logic [31:0] b_next [4];
    logic [31:0] a_next [4];
    logic [A-1:0] idx_reg [4];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ha_reg[0] <= 32'(x0 * HASH_MUL_A);
            ha_reg[1] <= 32'(x1 * HASH_MUL_A);
            y0_reg    <= y0;
            y1_reg    <= y1;
        end
    end

    always_comb
    begin
        b_next[0] = 32'((y0_reg ^ rotl16(ha_reg[0])) * HASH_MUL_B);
        b_next[1] = 32'((y0_reg ^ rotl16(ha_reg[1])) * HASH_MUL_B);
        b_next[2] = 32'((y1_reg ^ rotl16(ha_reg[0])) * HASH_MUL_B);
        b_next[3] = 32'((y1_reg ^ rotl16(ha_reg[1])) * HASH_MUL_B);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_reg        <= b_next;
            hb_ha_reg[0] <= ha_reg[0];
            hb_ha_reg[1] <= ha_reg[1];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            a_next[c] = 32'((hb_ha_reg[c % 2] ^ rotl16(b_reg[c])) * HASH_MUL_C);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int c = 0; c < 4; c++)
            begin
                idx_reg[c] <= a_next[c][31 -: A];
            end
        end
    end

    assign idx = idx_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pnd_grad_lut.sv
// Gradient lookup: quarter-wave cos/sin table and quadrant mapping, registered.
// Depends on pnd_pkg.
`default_nettype none
module pnd_grad_lut
    import pnd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [A-1:0]         idx [4],
    output logic signed [GW-1:0]      gx [4],
    output logic signed [GW-1:0]      gy [4]
);

    grad_t lut [QN];
    logic signed [GW-1:0] gx_reg [4];
    logic signed [GW-1:0] gy_reg [4];
    logic signed [GW-1:0] gx_next [4];
    logic signed [GW-1:0] gy_next [4];

    for (genvar i = 0; i < QN; i++)
    begin : g_lut
        localparam grad_t ENTRY = quarter_of(i);
        assign lut[i] = ENTRY;
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            case (idx[c][A-1 -: 2])
                QUAD_0:
                begin
                    gx_next[c] = lut[idx[c][A-3:0]].c;
                    gy_next[c] = lut[idx[c][A-3:0]].s;
                end
                QUAD_1:
                begin
                    gx_next[c] = -lut[idx[c][A-3:0]].s;
                    gy_next[c] = lut[idx[c][A-3:0]].c;
                end
                QUAD_2:
                begin
                    gx_next[c] = -lut[idx[c][A-3:0]].c;
                    gy_next[c] = -lut[idx[c][A-3:0]].s;
                end
                default:
                begin
                    gx_next[c] = lut[idx[c][A-3:0]].s;
                    gy_next[c] = -lut[idx[c][A-3:0]].c;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
    end

    assign gx = gx_reg;
    assign gy = gy_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pnd_fade.sv
// Smootherstep weight 6t^5-15t^4+10t^3 over three stages.
// Depends on pnd_pkg.
`default_nettype none
module pnd_fade
    import pnd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic [2:0]    en,   // load enables, stages 2..4
    input  wire logic [F-1:0]  f,
    output logic      [F:0]    s
);

    localparam int IW = F + 5;

    logic [F-1:0]  t2_reg;
    logic [F-1:0]  f2_reg;
    logic [F-1:0]  t3_reg;
    logic [IW-1:0] in_reg;
    logic [IW-1:0] in_next;
    logic [F:0]    s_reg;
    logic [F:0]    s_next;
    logic [F+IW-1:0] prod;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t2_reg <= F'((2 * F)'(f * f) >> F);
            f2_reg <= f;
        end
    end

    assign in_next = IW'(10 << F) - IW'(15 * f2_reg) + IW'(6 * t2_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t3_reg <= F'((2 * F)'(t2_reg * f2_reg) >> F);
            in_reg <= in_next;
        end
    end

    assign prod   = (F + IW)'(t3_reg * in_reg);
    assign s_next = ((prod >> F) > (F + IW)'(1 << F)) ? (F + 1)'(1 << F)
                                                     : (F + 1)'(prod >> F);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s_reg <= s_next;
        end
    end

    assign s = s_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pnd_checker.sv
// Port-level checks on the noise pipeline, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pnd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] noise_value
);

    // stalled output beat stays
    `PND_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `PND_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(noise_value))
    // input side blocks only when a result is held at the output
    `PND_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready)
    // pipeline comes out of reset empty
    `PND_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind perlin_noise_2d_top pnd_checker u_pnd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value)
);
`default_nettype wire
